// File: rtl/mexp_pkg.sv
// Shared constants, types and codes for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int WORD_BITS_DEFAULT = 16;
   localparam int CSR_INDEX_BITS    = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS  = 1'b0,
      CSR_EXPONENT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_REDUCE   = 2'd0,
      OP_MULTIPLY = 2'd1,
      OP_SQUARE   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_BUSY   = 2'd1,
      ST_DECIDE = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic   load;
      logic   mul_start;
      op_type op;
      logic   exp_clear_low;
      logic   exp_shift;
      logic   rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic exp_zero;
      logic exp_low;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: rtl/mexp_if.sv
// Request and response channel interfaces of the modular exponentiation block.
`timescale 1ns / 1ps

interface mexp_req_if #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] message;

   modport source (output valid, output message, input ready);
   modport sink   (input valid, input message, output ready);
endinterface

interface mexp_rsp_if #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] ciphertext;

   modport source (output valid, output ciphertext, input ready);
   modport sink   (input valid, input ciphertext, output ready);
endinterface

// File: rtl/mexp_modmul.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module mexp_modmul #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] operand_a,
   input  logic [WORD_BITS-1:0] operand_b,
   input  logic [WORD_BITS:0]   modulus_ext,
   output logic                 done,
   output logic [WORD_BITS-1:0] product
);

   localparam int CntBits = $clog2(WORD_BITS);
   localparam logic [CntBits-1:0] CntLast = CntBits'(WORD_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] r_ff, r_in;

   logic [WORD_BITS:0]   dbl_sum;
   logic [WORD_BITS-1:0] dbl_red;
   logic [WORD_BITS:0]   add_sum;
   logic [WORD_BITS-1:0] add_red;

   // r = 2r mod m, then r = r + a mod m when the multiplier bit is set
   always_comb begin
      dbl_sum = {1'b0, r_ff} + {1'b0, r_ff};
      dbl_red = (dbl_sum >= modulus_ext) ? WORD_BITS'(dbl_sum - modulus_ext)
                                         : dbl_sum[WORD_BITS-1:0];
      add_sum = {1'b0, dbl_red} + {1'b0, a_ff};
      add_red = (add_sum >= modulus_ext) ? WORD_BITS'(add_sum - modulus_ext)
                                         : add_sum[WORD_BITS-1:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         a_in     = operand_a;
         b_in     = operand_b;
         r_in     = '0;
      end else if (busy_ff) begin
         r_in     = b_ff[WORD_BITS-1] ? add_red : dbl_red;
         b_in     = {b_ff[WORD_BITS-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CntLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

// File: rtl/mexp_datapath.sv
// Datapath: configuration registers, base, accumulator, exponent shifter, output beat.
`timescale 1ns / 1ps

module mexp_datapath #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mexp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]                csr_write_data,
   input  logic [WORD_BITS-1:0]                req_message,
   input  mexp_pkg::dp_cmd_type                cmd,
   output mexp_pkg::dp_status_type             status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [WORD_BITS-1:0]                rsp_ciphertext
);

   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   mexp_pkg::op_type     op_ff, op_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] ciphertext_ff, ciphertext_in;

   logic [WORD_BITS:0]   modulus_ext;
   logic [WORD_BITS-1:0] operand_a;
   logic [WORD_BITS-1:0] operand_b;
   logic                 mul_done;
   logic [WORD_BITS-1:0] product;

   // a zero modulus stands for 2^WORD_BITS
   assign modulus_ext = {(modulus_ff == '0), modulus_ff};

   always_comb begin
      case (cmd.op)
         mexp_pkg::OP_REDUCE: begin
            operand_a = WORD_BITS'(1);
            operand_b = req_message;
         end
         mexp_pkg::OP_MULTIPLY: begin
            operand_a = base_ff;
            operand_b = acc_ff;
         end
         mexp_pkg::OP_SQUARE: begin
            operand_a = base_ff;
            operand_b = base_ff;
         end
         default: begin
            operand_a = base_ff;
            operand_b = base_ff;
         end
      endcase
   end

   mexp_modmul #(
      .WORD_BITS (WORD_BITS)
   ) u_modmul (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.mul_start),
      .operand_a   (operand_a),
      .operand_b   (operand_b),
      .modulus_ext (modulus_ext),
      .done        (mul_done),
      .product     (product)
   );

   always_comb begin
      modulus_in    = modulus_ff;
      exponent_in   = exponent_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      exp_in        = exp_ff;
      op_in         = op_ff;
      rsp_valid_in  = rsp_valid_ff;
      ciphertext_in = ciphertext_ff;

      if (csr_write_enable) begin
         case (mexp_pkg::csr_index_type'(csr_index))
            mexp_pkg::CSR_MODULUS:  modulus_in  = csr_write_data;
            mexp_pkg::CSR_EXPONENT: exponent_in = csr_write_data;
            default: ;
         endcase
      end

      if (cmd.mul_start) begin
         op_in = cmd.op;
      end
      if (cmd.load) begin
         acc_in = WORD_BITS'(1);
         exp_in = exponent_ff;
      end
      if (cmd.exp_clear_low) begin
         exp_in = {exp_ff[WORD_BITS-1:1], 1'b0};
      end
      if (cmd.exp_shift) begin
         exp_in = {1'b0, exp_ff[WORD_BITS-1:1]};
      end

      if (mul_done) begin
         case (op_ff)
            mexp_pkg::OP_MULTIPLY: acc_in  = product;
            mexp_pkg::OP_REDUCE:   base_in = product;
            mexp_pkg::OP_SQUARE:   base_in = product;
            default:               base_in = product;
         endcase
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         ciphertext_in = acc_ff;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WORD_BITS'(1);
         exponent_ff  <= WORD_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      exp_ff        <= exp_in;
      op_ff         <= op_in;
      ciphertext_ff <= ciphertext_in;
   end

   assign status.mul_done = mul_done;
   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_low  = exp_ff[0];
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = ciphertext_ff;

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences reduction, multiplies and squarings over the exponent bits.
`timescale 1ns / 1ps

module mexp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mexp_pkg::dp_status_type status,
   output mexp_pkg::dp_cmd_type    cmd
);

   mexp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = mexp_pkg::OP_REDUCE;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load      = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.op        = mexp_pkg::OP_REDUCE;
               state_in      = mexp_pkg::ST_BUSY;
            end
         end
         mexp_pkg::ST_BUSY: begin
            if (status.mul_done) begin
               state_in = mexp_pkg::ST_DECIDE;
            end
         end
         mexp_pkg::ST_DECIDE: begin
            if (status.exp_zero) begin
               state_in = mexp_pkg::ST_FINISH;
            end else if (status.exp_low) begin
               cmd.mul_start     = 1'b1;
               cmd.op            = mexp_pkg::OP_MULTIPLY;
               cmd.exp_clear_low = 1'b1;
               state_in          = mexp_pkg::ST_BUSY;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.op        = mexp_pkg::OP_SQUARE;
               cmd.exp_shift = 1'b1;
               state_in      = mexp_pkg::ST_BUSY;
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: message^exponent mod modulus.
//
//   channel  direction  payload                       beat taken when
//   req_if   in         message    [WORD_BITS-1:0]    valid && ready
//   rsp_if   out        ciphertext [WORD_BITS-1:0]    valid && ready
//   csr_*    in         index, write data             csr_write_enable
//
// One item at a time. Each item runs through the shared bit-serial multiplier as
// one reduction of the message, one multiply per set bit of the exponent and the
// squarings, before the next request is accepted, squarings numbering the
// exponent's bit length less one (none for zero).
// Reset is synchronous; modulus and exponent come up as 1, no beat pending.
// A result waiting on rsp_if does not block acceptance of the next request beat.
`timescale 1ns / 1ps

module modular_exponentiation #(
   parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [mexp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]                csr_write_data,
   mexp_req_if.sink                            req_if,
   mexp_rsp_if.source                          rsp_if
);

   mexp_pkg::dp_cmd_type    cmd;
   mexp_pkg::dp_status_type status;
   logic                    req_ready;

   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_message      (req_if.message),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_ciphertext   (rsp_if.ciphertext)
   );

   assign req_if.ready = req_ready;

endmodule
